[rtl/gww_pkg.sv]
package gww_pkg;

    // Register reset values and character codes
    localparam logic [5:0] LINE_WIDTH_RST = 6'd21;
    localparam logic [7:0] MAX_LINES_RST  = 8'd24;
    localparam logic [7:0] SPACE_CODE     = 8'h20;
    localparam logic [7:0] EOT_CODE       = 8'h00;

    // Configuration register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_MAX_LINES  = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LATCH      = 4'd1,
        OP_STORE      = 4'd2,
        OP_EOT        = 4'd3,
        OP_BRK_SPACE  = 4'd4,
        OP_BRK_WORD   = 4'd5,
        OP_BRK_HARD   = 4'd6,
        OP_SHIFT_GO   = 4'd7,
        OP_TAIL_STORE = 4'd8,
        OP_TAIL_DROP  = 4'd9
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    // Status flags seen by the controller
    typedef struct packed {
        logic eot;       // latched char ends the text
        logic space;     // latched char is a space
        logic limit;     // line limit reached
        logic skipping;  // dropping leading spaces
        logic fits;      // line not yet full
        logic seen;      // line holds a space
        logic at_cap;    // line buffer full to its physical size
        logic busy;      // emit or shift still running
    } stat_t;

endpackage

[rtl/greedy_word_wrap.sv]
// Greedy word wrap of a byte stream. Each input transfer carries one text byte
// (0 ends the text, 0x20 is a space); each output transfer carries one character
// of an emitted line (or none, to close a text) with its line number and
// end-of-line / end-of-text flags. An ordinary character is captured, then
// decided on and written into the line store. A break on a space, a hard
// break and a word break stream the emitted line out, and a word break then
// also moves the characters it carries: the line store has a single
// registered read port, which streams the emitted line out and then moves the
// carried word down one character per cycle. End of text flushes the
// characters still in the line. Receiver stalls add to the emit time. The
// output register lets the next byte be taken while the last result still
// waits.
// line_width and max_lines may be written only while the block is idle.
module greedy_word_wrap #(
    parameter int LINE_CHARS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_char_valid,
    output logic [7:0] m_line_number,
    output logic       m_line_end,
    output logic       m_text_done
);

    gww_pkg::cmd_t  cmd;
    gww_pkg::stat_t stat;

    gww_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gww_dp #(
        .LINE_CHARS (LINE_CHARS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_char_code   (s_char_code),
        .cmd           (cmd),
        .stat          (stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_char    (m_out_char),
        .m_char_valid  (m_char_valid),
        .m_line_number (m_line_number),
        .m_line_end    (m_line_end),
        .m_text_done   (m_text_done)
    );

endmodule

[rtl/gww_ctrl.sv]
module gww_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gww_pkg::stat_t stat,
    output gww_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DECIDE    = 6'b000010,
        ST_EMIT_WAIT = 6'b000100,
        ST_BRK_WAIT  = 6'b001000,
        ST_SHIFT     = 6'b010000,
        ST_TAIL      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = gww_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = gww_pkg::OP_LATCH;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.eot) begin
                    cmd.op     = gww_pkg::OP_EOT;
                    state_next = ST_EMIT_WAIT;
                end else if (stat.limit || (stat.skipping && stat.space)) begin
                    state_next = ST_IDLE;
                end else if (stat.fits) begin
                    cmd.op     = gww_pkg::OP_STORE;
                    state_next = ST_IDLE;
                end else if (stat.space) begin
                    cmd.op     = gww_pkg::OP_BRK_SPACE;
                    state_next = ST_EMIT_WAIT;
                end else if (stat.seen) begin
                    cmd.op     = gww_pkg::OP_BRK_WORD;
                    state_next = ST_BRK_WAIT;
                end else begin
                    cmd.op     = gww_pkg::OP_BRK_HARD;
                    state_next = ST_BRK_WAIT;
                end
            end
            ST_EMIT_WAIT: begin
                if (!stat.busy) state_next = ST_IDLE;
            end
            ST_BRK_WAIT: begin
                // line read out; now move the carried word down
                if (!stat.busy) begin
                    cmd.op     = gww_pkg::OP_SHIFT_GO;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!stat.busy) state_next = ST_TAIL;
            end
            ST_TAIL: begin
                cmd.op     = (stat.limit || stat.at_cap) ? gww_pkg::OP_TAIL_DROP
                                                         : gww_pkg::OP_TAIL_STORE;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/gww_dp.sv]
module gww_dp #(
    parameter int LINE_CHARS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [0:0]     cfg_index,
    input  logic [7:0]     cfg_wdata,
    input  logic [7:0]     s_char_code,
    input  gww_pkg::cmd_t  cmd,
    output gww_pkg::stat_t stat,
    input  logic           m_ready,
    output logic           m_valid,
    output logic [7:0]     m_out_char,
    output logic           m_char_valid,
    output logic [7:0]     m_line_number,
    output logic           m_line_end,
    output logic           m_text_done
);

    localparam int FW = $clog2(LINE_CHARS + 1);
    localparam int IW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam int CW = (FW > 7) ? FW : 7;

    // Configuration
    logic [5:0] lw_reg;
    logic [7:0] ml_reg;

    // Text state
    logic [7:0]    char_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [IW-1:0] lsp_reg, lsp_next;
    logic          seen_reg, seen_next;
    logic          skip_reg, skip_next;
    logic [7:0]    lines_reg, lines_next;

    // Emit unit
    logic [FW-1:0] em_idx_reg, em_len_reg;
    logic [7:0]    em_line_reg;
    logic          em_done_reg, em_empty_reg;
    logic          rd_pend_reg, rd_last_reg;
    logic [7:0]    rd_data_reg;

    // Shift unit
    logic          sh_run_reg, sh_pend_reg;
    logic [FW-1:0] sh_left_reg, sh_src_reg;
    logic [IW-1:0] sh_dst_reg, sh_wdst_reg;

    // Output register
    logic       m_valid_reg, m_cvalid_reg, m_lend_reg, m_done_reg;
    logic [7:0] m_char_reg, m_line_reg;

    // Line store
    logic [7:0]    mem [LINE_CHARS];
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    gww_pkg::op_t  op;
    logic [CW-1:0] lw_ext, cap, effw;
    logic          is_space, limit;
    logic          out_free, em_left, em_issue, rd_load, empty_load, sh_issue;
    logic          em_start, eot_has_line;
    logic [FW-1:0] em_len_start, rem_cnt;

    assign op = cmd.op;

    // Effective width: zero acts as one, clipped to the buffer size
    assign lw_ext = CW'(lw_reg);
    assign cap    = CW'(LINE_CHARS);
    always_comb begin
        if (lw_ext == '0)     effw = CW'(1);
        else if (lw_ext > cap) effw = cap;
        else                   effw = lw_ext;
    end

    assign is_space = (char_reg == gww_pkg::SPACE_CODE);
    assign limit    = (lines_reg >= ml_reg);
    assign rem_cnt  = fill_reg - FW'(lsp_reg) - FW'(1);

    // Handshake of the emit pipeline and shift sweep
    assign out_free   = !m_valid_reg || m_ready;
    assign em_left    = (em_idx_reg != em_len_reg);
    assign rd_load    = rd_pend_reg && out_free;
    assign em_issue   = em_left && (!rd_pend_reg || out_free);
    assign empty_load = em_empty_reg && out_free;
    assign sh_issue   = sh_run_reg && (sh_left_reg != '0);

    assign stat.eot      = (char_reg == gww_pkg::EOT_CODE);
    assign stat.space    = is_space;
    assign stat.limit    = limit;
    assign stat.skipping = skip_reg;
    assign stat.fits     = (CW'(fill_reg) < effw);
    assign stat.seen     = seen_reg;
    assign stat.at_cap   = (fill_reg >= FW'(LINE_CHARS));
    assign stat.busy     = em_left || rd_pend_reg || em_empty_reg ||
                           (sh_run_reg && (sh_left_reg != '0)) || sh_pend_reg;

    // Memory port selection
    assign mem_re    = em_issue || sh_issue;
    assign mem_raddr = em_issue ? em_idx_reg[IW-1:0] : sh_src_reg[IW-1:0];
    assign mem_we    = sh_pend_reg || (op == gww_pkg::OP_STORE) ||
                       (op == gww_pkg::OP_TAIL_STORE);
    assign mem_waddr = sh_pend_reg ? sh_wdst_reg : fill_reg[IW-1:0];
    assign mem_wdata = sh_pend_reg ? rd_data_reg : char_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= mem[mem_raddr];
    end

    // Emit length chosen at the start of a line readout
    assign eot_has_line = (fill_reg != '0) && !limit;
    always_comb begin
        em_start     = 1'b1;
        em_len_start = fill_reg;
        case (op)
            gww_pkg::OP_EOT:       em_len_start = eot_has_line ? fill_reg : '0;
            gww_pkg::OP_BRK_SPACE: em_len_start = fill_reg;
            gww_pkg::OP_BRK_WORD:  em_len_start = FW'(lsp_reg);
            gww_pkg::OP_BRK_HARD:  em_len_start = fill_reg;
            default:               em_start     = 1'b0;
        endcase
    end

    // Text state update
    always_comb begin
        fill_next  = fill_reg;
        lsp_next   = lsp_reg;
        seen_next  = seen_reg;
        skip_next  = skip_reg;
        lines_next = lines_reg;
        unique case (op)
            gww_pkg::OP_STORE: begin
                if (is_space) begin
                    lsp_next  = fill_reg[IW-1:0];
                    seen_next = 1'b1;
                end
                fill_next = fill_reg + FW'(1);
                skip_next = 1'b0;
            end
            gww_pkg::OP_EOT: begin
                fill_next  = '0;
                lsp_next   = '0;
                seen_next  = 1'b0;
                skip_next  = 1'b1;
                lines_next = '0;
            end
            gww_pkg::OP_BRK_SPACE: begin
                fill_next  = '0;
                lsp_next   = '0;
                seen_next  = 1'b0;
                skip_next  = 1'b1;
                lines_next = lines_reg + 8'd1;
            end
            gww_pkg::OP_BRK_WORD: begin
                // a space in the first position emits nothing
                fill_next  = rem_cnt;
                lsp_next   = '0;
                seen_next  = 1'b0;
                lines_next = (lsp_reg != '0) ? lines_reg + 8'd1 : lines_reg;
            end
            gww_pkg::OP_BRK_HARD: begin
                fill_next  = '0;
                lsp_next   = '0;
                seen_next  = 1'b0;
                lines_next = lines_reg + 8'd1;
            end
            gww_pkg::OP_TAIL_STORE: begin
                fill_next = fill_reg + FW'(1);
                skip_next = 1'b0;
            end
            gww_pkg::OP_TAIL_DROP: begin
                fill_next = '0;
                skip_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            lsp_reg   <= '0;
            seen_reg  <= 1'b0;
            skip_reg  <= 1'b1;
            lines_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            lsp_reg   <= lsp_next;
            seen_reg  <= seen_next;
            skip_reg  <= skip_next;
            lines_reg <= lines_next;
        end
    end

    // Input byte capture
    always_ff @(posedge aclk) begin
        if (op == gww_pkg::OP_LATCH) char_reg <= s_char_code;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= gww_pkg::LINE_WIDTH_RST;
            ml_reg <= gww_pkg::MAX_LINES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gww_pkg::REG_LINE_WIDTH: lw_reg <= cfg_wdata[5:0];
                gww_pkg::REG_MAX_LINES:  ml_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Emit unit: one read per cycle while the output register is free, tagged with its line-end flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_idx_reg   <= '0;
            em_len_reg   <= '0;
            em_empty_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end else begin
            if (em_start) begin
                em_idx_reg   <= '0;
                em_len_reg   <= em_len_start;
                em_empty_reg <= (op == gww_pkg::OP_EOT) && !eot_has_line;
            end else begin
                if (em_issue) em_idx_reg <= em_idx_reg + FW'(1);
                if (empty_load) em_empty_reg <= 1'b0;
            end
            if (em_issue)     rd_pend_reg <= 1'b1;
            else if (rd_load) rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_start) begin
            em_line_reg <= lines_reg;
            em_done_reg <= (op == gww_pkg::OP_EOT);
        end
        if (em_issue) rd_last_reg <= ((em_idx_reg + FW'(1)) == em_len_reg);
    end

    // Shift unit: move the carried word to the start of the line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_run_reg  <= 1'b0;
            sh_left_reg <= '0;
            sh_pend_reg <= 1'b0;
        end else begin
            unique case (op) inside
                gww_pkg::OP_BRK_WORD: begin
                    sh_run_reg  <= 1'b0;
                    sh_left_reg <= rem_cnt;
                end
                gww_pkg::OP_BRK_HARD, gww_pkg::OP_BRK_SPACE: begin
                    sh_run_reg  <= 1'b0;
                    sh_left_reg <= '0;
                end
                gww_pkg::OP_SHIFT_GO: sh_run_reg <= 1'b1;
                default: begin
                    if (sh_issue) sh_left_reg <= sh_left_reg - FW'(1);
                end
            endcase
            sh_pend_reg <= sh_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == gww_pkg::OP_BRK_WORD) begin
            sh_src_reg <= FW'(lsp_reg) + FW'(1);
        end else if (sh_issue) begin
            sh_src_reg <= sh_src_reg + FW'(1);
        end
        if (op == gww_pkg::OP_SHIFT_GO) begin
            sh_dst_reg <= '0;
        end else if (sh_issue) begin
            sh_dst_reg <= sh_dst_reg + IW'(1);
        end
        if (sh_issue) sh_wdst_reg <= sh_dst_reg;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rd_load || empty_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_load) begin
            m_char_reg   <= rd_data_reg;
            m_cvalid_reg <= 1'b1;
            m_line_reg   <= em_line_reg;
            m_lend_reg   <= rd_last_reg;
            m_done_reg   <= em_done_reg && rd_last_reg;
        end else if (empty_load) begin
            m_char_reg   <= 8'd0;
            m_cvalid_reg <= 1'b0;
            m_line_reg   <= em_line_reg;
            m_lend_reg   <= 1'b0;
            m_done_reg   <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_char_reg;
    assign m_char_valid  = m_cvalid_reg;
    assign m_line_number = m_line_reg;
    assign m_line_end    = m_lend_reg;
    assign m_text_done   = m_done_reg;

endmodule

[rtl/gww_checker.sv]
module gww_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_char_valid,
    input logic [7:0] m_line_number,
    input logic       m_line_end,
    input logic       m_text_done
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) &&
        $stable(m_char_valid) && $stable(m_line_number) &&
        $stable(m_line_end) && $stable(m_text_done))
        else $error("result changed while stalled");

    // Empty result only closes a text and carries no character
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_out_char == 8'd0 && m_text_done && !m_line_end)
        else $error("malformed empty result");

    // Final character of a text also ends its line
    a_done_lend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid && m_text_done |-> m_line_end)
        else $error("text done without line end");

    // One byte at a time: ready drops after each transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_char    (m_out_char),
    .m_char_valid  (m_char_valid),
    .m_line_number (m_line_number),
    .m_line_end    (m_line_end),
    .m_text_done   (m_text_done)
);
